[rtl/sad_pkg.sv]
// Shared constants and types of the sound activity detector.
package sad_pkg;

    localparam int          SAD_WINDOW_LEN  = 16;
    localparam int          SAD_SAMPLE_BITS = 12;
    localparam logic [31:0] SAD_HOLDOFF_MS  = 32'd65535;

    localparam int SUM_W    = 16;
    localparam int LEVEL_W  = 16;
    localparam int ACT_W    = 12;
    localparam int FLOOR_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [ACT_W-1:0]   ACT_MAX    = '1;
    localparam logic [FLOOR_W-1:0] FLOOR_INIT = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX    = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE    = 2'd0,
        CFG_THRESHOLD = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic                window_done;
        logic [ACT_W-1:0]    activity;
        logic                sound_event;
        logic                is_triggered;
        logic [LEVEL_W-1:0]  peak_level;
        logic [FLOOR_W-1:0]  quiet_level;
        logic                status_report;
    } t_result;

endpackage

[rtl/sound_activity_detector_top.sv]
// Sound activity detector: windowed sample-difference level, trigger and event logic.
// A result is registered at the output, or in a skid entry while the output is held.
// Throughput: one item per cycle unless stalled; each item is one pass through the
// difference, window-sum and reciprocal-multiply logic ahead of the result register.
// A two-entry output buffer keeps intake running while one result waits.
// Reset is synchronous, active low: detector disabled, triggered set, floor at 255.
module sound_activity_detector_top #(
    parameter int          WINDOW_LEN       = sad_pkg::SAD_WINDOW_LEN,
    parameter int          SAMPLE_BITS      = sad_pkg::SAD_SAMPLE_BITS,
    parameter logic [31:0] EVENT_HOLDOFF_MS = sad_pkg::SAD_HOLDOFF_MS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sad_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sad_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input item channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [SAMPLE_BITS-1:0]         i_sample,
    input  logic [31:0]                    i_now_ms,
    input  logic                           i_display_on,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_window_done,
    output logic [sad_pkg::ACT_W-1:0]      o_activity,
    output logic                           o_sound_event,
    output logic                           o_is_triggered,
    output logic [sad_pkg::LEVEL_W-1:0]    o_peak_level,
    output logic [sad_pkg::FLOOR_W-1:0]    o_quiet_level,
    output logic                           o_status_report
);
    import sad_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_LEN);
    // Exact division of a 16-bit sum by WINDOW_LEN: q = (x * m) >> (16 + l),
    // with l = ceil(log2 W) and m = ceil(2^(16+l) / W).
    localparam int RSH = SUM_W + $clog2(WINDOW_LEN);
    localparam logic [SUM_W:0] RECIP =
        (SUM_W + 1)'(((64'd1 << RSH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_LEN - 1);

    // detector state
    logic                   r_enable, n_enable;
    logic [LEVEL_W-1:0]     r_threshold, n_threshold;
    logic [SAMPLE_BITS-1:0] r_last, n_last;
    logic                   r_have_base, n_have_base;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_trig, n_trig;
    logic [LEVEL_W-1:0]     r_ceil, n_ceil;
    logic [FLOOR_W-1:0]     r_floor, n_floor;
    logic [31:0]            r_last_ev, n_last_ev;
    logic                   r_pending, n_pending;

    // output buffer
    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    logic                   in_accept;
    logic                   out_fire;
    logic [SAMPLE_BITS-1:0] diff;
    logic [SUM_W:0]         sum_wide;
    logic [SUM_W-1:0]       sum_sat;
    logic [2*SUM_W:0]       prod;
    logic [LEVEL_W-1:0]     act_full;
    logic [31:0]            elapsed;
    t_result                res;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_fire    = r_out_valid && !i_out_stall;

    assign diff     = (i_sample >= r_last) ? (i_sample - r_last) : (r_last - i_sample);
    assign sum_wide = (SUM_W + 1)'(r_sum) + (SUM_W + 1)'(diff);
    assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    assign prod     = (2 * SUM_W + 1)'(sum_sat) * (2 * SUM_W + 1)'(RECIP);
    assign act_full = LEVEL_W'(prod >> RSH);
    assign elapsed  = i_now_ms - r_last_ev;

    always_comb begin
        n_enable    = r_enable;
        n_threshold = r_threshold;
        n_last      = r_last;
        n_have_base = r_have_base;
        n_sum       = r_sum;
        n_count     = r_count;
        n_trig      = r_trig;
        n_ceil      = r_ceil;
        n_floor     = r_floor;
        n_last_ev   = r_last_ev;
        n_pending   = r_pending;

        res.window_done   = 1'b0;
        res.activity      = '0;
        res.sound_event   = 1'b0;
        res.status_report = 1'b0;

        if (in_accept) begin
            if (r_pending) begin
                // A pending report takes this item; the sample is dropped.
                n_pending         = 1'b0;
                res.status_report = 1'b1;
            end else if (r_enable && i_display_on) begin
                n_last = i_sample;
                if (!r_have_base) begin
                    n_have_base = 1'b1;
                end else if (r_count == CNT_LAST) begin
                    res.window_done = 1'b1;
                    res.activity    = (act_full > LEVEL_W'(ACT_MAX)) ? ACT_MAX
                                                                     : act_full[ACT_W-1:0];
                    if (act_full > r_threshold) begin
                        if (!r_trig) begin
                            n_trig = 1'b1;
                            if (elapsed > EVENT_HOLDOFF_MS) begin
                                res.sound_event = 1'b1;
                                n_last_ev       = i_now_ms;
                            end
                        end else if (act_full > r_ceil) begin
                            n_ceil    = act_full;
                            n_pending = 1'b1;
                        end
                    end else if (r_trig) begin
                        n_trig = 1'b0;
                    end else if (act_full < LEVEL_W'(r_floor)) begin
                        n_floor   = act_full[FLOOR_W-1:0];
                        n_pending = 1'b1;
                    end
                    n_sum   = '0;
                    n_count = '0;
                end else begin
                    n_sum   = sum_sat;
                    n_count = r_count + CNT_W'(1);
                end
            end
        end

        res.is_triggered = n_trig;
        res.peak_level   = n_ceil;
        res.quiet_level  = n_floor;

        // Users write configuration only while no item is in flight; not enforced.
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENABLE: begin
                    if (i_cfg_data[0] != r_enable) begin
                        if (i_cfg_data[0]) begin
                            n_sum       = '0;
                            n_count     = '0;
                            n_have_base = 1'b0;
                        end
                        n_enable  = i_cfg_data[0];
                        n_trig    = !i_cfg_data[0];
                        n_pending = 1'b1;
                    end
                end
                CFG_THRESHOLD: begin
                    n_threshold = i_cfg_data[LEVEL_W-1:0];
                    n_pending   = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = res;
                n_out_valid = in_accept;
            end
        end else if (in_accept) begin
            n_skid       = res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_threshold  <= '0;
            r_last       <= '0;
            r_have_base  <= 1'b0;
            r_sum        <= '0;
            r_count      <= '0;
            r_trig       <= 1'b1;
            r_ceil       <= '0;
            r_floor      <= FLOOR_INIT;
            r_last_ev    <= '0;
            r_pending    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_enable     <= n_enable;
            r_threshold  <= n_threshold;
            r_last       <= n_last;
            r_have_base  <= n_have_base;
            r_sum        <= n_sum;
            r_count      <= n_count;
            r_trig       <= n_trig;
            r_ceil       <= n_ceil;
            r_floor      <= n_floor;
            r_last_ev    <= n_last_ev;
            r_pending    <= n_pending;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid     = r_out_valid;
    assign o_window_done   = r_out.window_done;
    assign o_activity      = r_out.activity;
    assign o_sound_event   = r_out.sound_event;
    assign o_is_triggered  = r_out.is_triggered;
    assign o_peak_level    = r_out.peak_level;
    assign o_quiet_level   = r_out.quiet_level;
    assign o_status_report = r_out.status_report;

endmodule

[rtl/sad_checker.sv]
// Port-level checks of the sound activity detector, bound to its top level.
module sad_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic                           o_window_done,
    input logic [sad_pkg::ACT_W-1:0]      o_activity,
    input logic                           o_sound_event,
    input logic                           o_is_triggered,
    input logic [sad_pkg::LEVEL_W-1:0]    o_peak_level,
    input logic [sad_pkg::FLOOR_W-1:0]    o_quiet_level,
    input logic                           o_status_report
);
    import sad_pkg::*;

    // The intake only stalls while a finished result is waiting downstream.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result held");

    // Intake stalls only after a result was held back and another item came in.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall && i_in_valid))
        else $error("input stall rose without a held result and new item");

    // A sound event comes only from a closed window and leaves the flag set.
    a_event_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sound_event) |-> (o_window_done && o_is_triggered))
        else $error("sound event without closed window or triggered flag");

    // A report item and an unfinished window carry no activity.
    a_report_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status_report || !o_window_done)) |->
            (o_activity == '0 && !o_sound_event && !(o_status_report && o_window_done)))
        else $error("activity shown on a report or open-window item");

    // A held result keeps its activity, levels and report flag while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_activity) && $stable(o_peak_level)
             && $stable(o_quiet_level) && $stable(o_status_report)))
        else $error("stalled result changed");

endmodule

bind sound_activity_detector_top sad_checker u_sad_checker (.*);

[test/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the sound activity detector: directed cases, then random windows.
module tb;
    import sad_pkg::*;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [31:0]          HOLDOFF   = SAD_HOLDOFF_MS;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_cfg_valid  = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data   = '0;
    logic                       i_in_valid   = 1'b0;
    logic                       o_in_stall;
    logic [SAD_SAMPLE_BITS-1:0] i_sample     = '0;
    logic [31:0]                i_now_ms     = '0;
    logic                       i_display_on = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall  = 1'b0;
    logic                       o_window_done;
    logic [ACT_W-1:0]           o_activity;
    logic                       o_sound_event;
    logic                       o_is_triggered;
    logic [LEVEL_W-1:0]         o_peak_level;
    logic [FLOOR_W-1:0]         o_quiet_level;
    logic                       o_status_report;

    sound_activity_detector_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .i_now_ms       (i_now_ms),
        .i_display_on   (i_display_on),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_window_done  (o_window_done),
        .o_activity     (o_activity),
        .o_sound_event  (o_sound_event),
        .o_is_triggered (o_is_triggered),
        .o_peak_level   (o_peak_level),
        .o_quiet_level  (o_quiet_level),
        .o_status_report(o_status_report)
    );

    always #10 i_clk = ~i_clk;

    // Detector state as the testbench tracks it.
    logic                       det_enable    = 1'b0;
    logic [CFG_DATA_W-1:0]      det_threshold = '0;
    logic [SAD_SAMPLE_BITS-1:0] prev_sample   = '0;
    logic                       have_base     = 1'b0;
    logic [SUM_W-1:0]           diff_acc      = '0;
    logic [4:0]                 diff_count    = '0;
    logic                       trig          = 1'b1;
    logic [LEVEL_W-1:0]         ceiling       = '0;
    logic [FLOOR_W-1:0]         floor_lvl     = FLOOR_INIT;
    logic [31:0]                last_event    = '0;
    logic                       report_due    = 1'b0;

    t_result     level_results[$];
    int          mismatches     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic [31:0] clock_ms       = '0;

    task automatic apply_config(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ENABLE: begin
                if (data[0] != det_enable) begin
                    if (data[0]) begin
                        diff_acc   = '0;
                        diff_count = '0;
                        have_base  = 1'b0;
                    end
                    det_enable = data[0];
                    trig       = ~data[0];
                    report_due = 1'b1;
                end
            end
            CFG_THRESHOLD: begin
                det_threshold = data;
                report_due    = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic predict_sample(input logic [SAD_SAMPLE_BITS-1:0] smp,
                                  input logic [31:0] now, input logic disp);
        t_result                    r;
        logic [SAD_SAMPLE_BITS-1:0] d;
        logic [SUM_W:0]             sum;
        logic [SUM_W-1:0]           act;
        r = '0;
        if (report_due) begin
            report_due      = 1'b0;
            r.status_report = 1'b1;
        end else if (det_enable && disp) begin
            if (!have_base) begin
                prev_sample = smp;
                have_base   = 1'b1;
            end else begin
                d           = (smp >= prev_sample) ? smp - prev_sample : prev_sample - smp;
                prev_sample = smp;
                sum         = {1'b0, diff_acc} + (SUM_W + 1)'(d);
                diff_acc    = sum[SUM_W] ? SUM_MAX : sum[SUM_W-1:0];
                diff_count  = diff_count + 5'd1;
                if (diff_count >= 5'(SAD_WINDOW_LEN)) begin
                    act           = SUM_W'(diff_acc / SAD_WINDOW_LEN);
                    r.window_done = 1'b1;
                    r.activity    = (act > SUM_W'(ACT_MAX)) ? ACT_MAX : act[ACT_W-1:0];
                    if (act > det_threshold) begin
                        if (!trig) begin
                            trig = 1'b1;
                            if (now - last_event > HOLDOFF) begin
                                r.sound_event = 1'b1;
                                last_event    = now;
                            end
                        end else if (act > ceiling) begin
                            ceiling    = act;
                            report_due = 1'b1;
                        end
                    end else if (trig) begin
                        trig = 1'b0;
                    end else if (act < SUM_W'(floor_lvl)) begin
                        floor_lvl  = act[FLOOR_W-1:0];
                        report_due = 1'b1;
                    end
                    diff_acc   = '0;
                    diff_count = '0;
                end
            end
        end
        r.is_triggered = trig;
        r.peak_level   = ceiling;
        r.quiet_level  = floor_lvl;
        level_results.push_back(r);
    endtask

    task automatic send_sample(input logic [SAD_SAMPLE_BITS-1:0] smp,
                               input logic [31:0] now, input logic disp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_sample     <= smp;
        i_now_ms     <= now;
        i_display_on <= disp;
        do @(posedge i_clk); while (o_in_stall);
        predict_sample(smp, now, disp);
    endtask

    // Holds off the sender until every expected result has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (level_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_config(idx, data);
    endtask

    task automatic write_enable(input logic on);
        logic [CFG_DATA_W-1:0] data;
        data    = CFG_DATA_W'($urandom);
        data[0] = on;
        write_reg(CFG_ENABLE, data);
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (level_results.size() == 0) begin
                $error("result with no item waiting for it");
                mismatches++;
            end else begin
                want = level_results.pop_front();
                check_field("window_done", 32'(want.window_done), 32'(o_window_done));
                check_field("activity", 32'(want.activity), 32'(o_activity));
                check_field("sound_event", 32'(want.sound_event), 32'(o_sound_event));
                check_field("is_triggered", 32'(want.is_triggered), 32'(o_is_triggered));
                check_field("peak_level", 32'(want.peak_level), 32'(o_peak_level));
                check_field("quiet_level", 32'(want.quiet_level), 32'(o_quiet_level));
                check_field("status_report", 32'(want.status_report),
                            32'(o_status_report));
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic test_disabled_after_reset();
        send_sample('1, 32'hFFFF_FFFF, 1'b1);
        send_sample('0, 32'h0, 1'b0);
    endtask

    task automatic test_ignored_writes();
        write_reg(CFG_SPARE, 16'hFFFF);
        // Bit 0 is clear, so this rewrites the current disabled state.
        write_reg(CFG_ENABLE, 16'hFFFE);
        send_sample(12'h800, 32'h8000_0000, 1'b1);
    endtask

    task automatic test_first_window();
        write_reg(CFG_THRESHOLD, 16'h0000);
        write_reg(CFG_ENABLE, 16'h0001);
        send_sample(12'h555, 32'h1, 1'b1);
        // Baseline, then a full-scale square wave; the timestamp sits just past the holdoff.
        send_sample('0, HOLDOFF + 32'd1, 1'b1);
        for (int k = 0; k < SAD_WINDOW_LEN; k++)
            send_sample((k % 2 == 0) ? 12'hFFF : 12'h000, HOLDOFF + 32'd1, 1'b1);
        send_sample(12'hABC, HOLDOFF + 32'd2, 1'b0);
    endtask

    task automatic test_disable();
        write_reg(CFG_THRESHOLD, 16'hFFFF);
        write_reg(CFG_ENABLE, 16'hAAAA);
        send_sample(12'h3C3, 32'h7FFF_FFFF, 1'b1);
    endtask

    task automatic send_window(input int thr);
        int                         amp;
        int                         base;
        int                         top;
        logic [SAD_SAMPLE_BITS-1:0] smp;
        logic                       disp;
        top = (thr < 4095) ? thr : 4095;
        if ($urandom_range(1) && thr < 4095)
            amp = $urandom_range(4095, thr + 1);
        else if ($urandom_range(1))
            amp = $urandom_range((top < 255) ? top : 255);
        else
            amp = $urandom_range(top);
        base = $urandom_range(4095 - amp);
        for (int k = 0; k < SAD_WINDOW_LEN; k++) begin
            if ($urandom_range(19) == 0)
                smp = SAD_SAMPLE_BITS'($urandom);
            else
                smp = SAD_SAMPLE_BITS'(base + ((k % 2 == 1) ? amp : 0));
            disp = ($urandom_range(15) != 0);
            if ($urandom_range(63) == 0)
                clock_ms = $urandom;
            else
                clock_ms = clock_ms + $urandom_range(2000);
            send_sample(smp, clock_ms, disp);
        end
    endtask

    task automatic test_random_windows(input int idle_pct, input int stall_pct,
                                       input logic [CFG_DATA_W-1:0] thr, input int windows);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_reg(CFG_THRESHOLD, thr);
        if (!det_enable)
            write_enable(1'b1);
        for (int w = 0; w < windows; w++) begin
            if (w == windows / 2) begin
                write_enable(1'b0);
                write_enable(1'b1);
            end
            send_window(int'(thr));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_disabled_after_reset();
        test_ignored_writes();
        test_first_window();
        test_disable();
        test_random_windows(0, 0, 16'($urandom_range(1500, 1)), 13);
        test_random_windows(88, 0, 16'h0000, 13);
        test_random_windows(0, 88, 16'hFFFF, 13);
        test_random_windows(22, 22, 16'($urandom_range(1500, 1)), 13);
        drain();
        repeat (5) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

[files.f]
rtl/sad_pkg.sv
rtl/sound_activity_detector_top.sv
rtl/sad_checker.sv
test/tb.sv
